// ===== hdl/mswd_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-slot watchdog package
// Request and status codes shared by the watchdog and its port checker.
// ----------------------------------------------------------------------------
package mswd_pkg;

    typedef logic [1:0] opcode_t;
    typedef logic [1:0] status_t;

    // Request codes
    localparam opcode_t OP_ALLOC   = 2'd0;
    localparam opcode_t OP_RELEASE = 2'd1;
    localparam opcode_t OP_KICK    = 2'd2;
    localparam opcode_t OP_TICK    = 2'd3;

    // Status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;
    localparam status_t ST_FREE  = 2'd3;

    localparam int SLOT_FIELD_W = 3;
    localparam int TMO_FIELD_W  = 16;

endpackage

// ===== hdl/multi_slot_software_watchdog.sv =====
// ----------------------------------------------------------------------------
// Multi-slot watchdog
// Table of watchdog slots with allocate, release, kick and tick requests.
// ----------------------------------------------------------------------------
// A user sends one request at a time on the s_ channel and receives exactly
// one answer on the m_ channel. An allocate request walks the in-use flags
// from slot 0 upward, one slot per cycle, then hands its answer over through
// the answer state to the output register. A tick walks the slots through the
// limit and count memories, one slot per cycle, with the memory read
// registered ahead of the judgement of each slot, then hands its answer over
// the same way; it stops early at the first expired slot. Release and kick do
// their work in the accept cycle and answer through the answer state as well.
// The one shared scan counter and the single read port of the slot memories
// make both walks go one slot at a time. The input is not ready while a
// request is at work, but a new request is taken while the previous answer
// still waits in the output register. No clearing pass runs after reset: the
// in-use flags are cleared at once and a free slot's memory words are never
// used before an allocate rewrites them.
// ----------------------------------------------------------------------------
module multi_slot_software_watchdog
    import mswd_pkg::*;
#(
    parameter int SLOT_COUNT  = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // request channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_opcode,
    input  logic [TMO_FIELD_W-1:0]  s_timeout_ticks,
    input  logic [SLOT_FIELD_W-1:0] s_slot_number,
    // answer channel
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic [SLOT_FIELD_W-1:0] m_granted_slot,
    output logic                    m_expired,
    output logic [SLOT_FIELD_W-1:0] m_expired_slot
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALLOC = 2'd1;
    localparam logic [1:0] S_TICK  = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]       eval_idx_reg, eval_idx_next;
    logic                   eval_valid_reg, eval_valid_next;
    logic [SLOT_COUNT-1:0]  in_use_reg, in_use_next;
    logic [TMO_FIELD_W-1:0] tmo_reg, tmo_next;

    // pending answer, built while the request is at work
    status_t                 res_status_reg, res_status_next;
    logic [SLOT_FIELD_W-1:0] res_granted_reg, res_granted_next;
    logic                    res_expired_reg, res_expired_next;
    logic [SLOT_FIELD_W-1:0] res_exp_slot_reg, res_exp_slot_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg;
    logic [SLOT_FIELD_W-1:0] m_granted_reg;
    logic                    m_expired_reg;
    logic [SLOT_FIELD_W-1:0] m_exp_slot_reg;
    logic                    out_load;

    // slot memories: limit and count, one read and one write port each
    logic [COUNT_WIDTH-1:0] lim_mem [SLOT_COUNT];
    logic [COUNT_WIDTH-1:0] cnt_mem [SLOT_COUNT];
    logic [COUNT_WIDTH-1:0] lim_rd_reg;
    logic [COUNT_WIDTH-1:0] cnt_rd_reg;
    logic                   lim_we;
    logic [COUNT_WIDTH-1:0] lim_wdata;
    logic                   cnt_we;
    logic [IDX_W-1:0]       cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;

    logic                   accept;
    logic [IDX_W-1:0]       sn_idx;
    logic                   sn_bad;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign sn_idx  = IDX_W'(s_slot_number);
    assign sn_bad  = ({29'd0, s_slot_number} >= 32'(SLOT_COUNT));

    // Saturating advance of the count read for the slot under evaluation
    assign cnt_inc = (cnt_rd_reg != {COUNT_WIDTH{1'b1}}) ?
                     cnt_rd_reg + COUNT_WIDTH'(1) : cnt_rd_reg;

    // Clamp the requested limit to the count range
    always_comb begin
        if (COUNT_WIDTH >= TMO_FIELD_W) begin
            lim_wdata = COUNT_WIDTH'(tmo_reg);
        end else if ((tmo_reg >> COUNT_WIDTH) != '0) begin
            lim_wdata = {COUNT_WIDTH{1'b1}};
        end else begin
            lim_wdata = COUNT_WIDTH'(tmo_reg);
        end
    end

    assign out_load = (state_reg == S_RESP) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next        = state_reg;
        scan_idx_next     = scan_idx_reg;
        eval_idx_next     = eval_idx_reg;
        eval_valid_next   = 1'b0;
        in_use_next       = in_use_reg;
        tmo_next          = tmo_reg;
        res_status_next   = res_status_reg;
        res_granted_next  = res_granted_reg;
        res_expired_next  = res_expired_reg;
        res_exp_slot_next = res_exp_slot_reg;
        lim_we            = 1'b0;
        cnt_we            = 1'b0;
        cnt_waddr         = scan_idx_reg;
        cnt_wdata         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_status_next   = ST_OK;
                    res_granted_next  = '0;
                    res_expired_next  = 1'b0;
                    res_exp_slot_next = '0;
                    scan_idx_next     = '0;
                    tmo_next          = s_timeout_ticks;
                    case (s_opcode)
                        OP_ALLOC: begin
                            state_next = S_ALLOC;
                        end
                        OP_RELEASE: begin
                            state_next = S_RESP;
                            if (sn_bad) begin
                                res_status_next = ST_RANGE;
                            end else if (!in_use_reg[sn_idx]) begin
                                res_status_next = ST_FREE;
                            end else begin
                                in_use_next[sn_idx] = 1'b0;
                            end
                        end
                        OP_KICK: begin
                            state_next = S_RESP;
                            if (sn_bad) begin
                                res_status_next = ST_RANGE;
                            end else begin
                                cnt_we    = 1'b1;
                                cnt_waddr = sn_idx;
                            end
                        end
                        default: begin
                            state_next = S_TICK;
                        end
                    endcase
                end
            end

            S_ALLOC: begin
                // Take the first free slot met on the walk
                if (!in_use_reg[scan_idx_reg]) begin
                    in_use_next[scan_idx_reg] = 1'b1;
                    lim_we           = 1'b1;
                    cnt_we           = 1'b1;
                    res_granted_next = SLOT_FIELD_W'(scan_idx_reg);
                    state_next       = S_RESP;
                end else if (scan_idx_reg == IDX_LAST) begin
                    res_status_next = ST_FULL;
                    state_next      = S_RESP;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end

            S_TICK: begin
                // Issue the read of the next slot while the previous one is judged
                eval_valid_next = 1'b1;
                eval_idx_next   = scan_idx_reg;
                if (scan_idx_reg != IDX_LAST) begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
                if (eval_valid_reg) begin
                    if (in_use_reg[eval_idx_reg]) begin
                        cnt_we    = 1'b1;
                        cnt_waddr = eval_idx_reg;
                        cnt_wdata = cnt_inc;
                    end
                    if (in_use_reg[eval_idx_reg] && (cnt_rd_reg > lim_rd_reg)) begin
                        res_expired_next  = 1'b1;
                        res_exp_slot_next = SLOT_FIELD_W'(eval_idx_reg);
                        state_next        = S_RESP;
                    end else if (eval_idx_reg == IDX_LAST) begin
                        state_next = S_RESP;
                    end
                end
            end

            S_RESP: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            eval_valid_reg <= 1'b0;
            in_use_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            eval_valid_reg <= eval_valid_next;
            in_use_reg     <= in_use_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload and counters
    always_ff @(posedge aclk) begin
        scan_idx_reg     <= scan_idx_next;
        eval_idx_reg     <= eval_idx_next;
        tmo_reg          <= tmo_next;
        res_status_reg   <= res_status_next;
        res_granted_reg  <= res_granted_next;
        res_expired_reg  <= res_expired_next;
        res_exp_slot_reg <= res_exp_slot_next;
        if (out_load) begin
            m_status_reg   <= res_status_reg;
            m_granted_reg  <= res_granted_reg;
            m_expired_reg  <= res_expired_reg;
            m_exp_slot_reg <= res_exp_slot_reg;
        end
    end

    // Slot memories
    always_ff @(posedge aclk) begin
        if (lim_we) begin
            lim_mem[scan_idx_reg] <= lim_wdata;
        end
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        lim_rd_reg <= lim_mem[scan_idx_reg];
        cnt_rd_reg <= cnt_mem[scan_idx_reg];
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_granted_slot = m_granted_reg;
    assign m_expired      = m_expired_reg;
    assign m_expired_slot = m_exp_slot_reg;

endmodule

// ===== hdl/mswd_checker.sv =====
// ----------------------------------------------------------------------------
// Multi-slot watchdog port checker
// Watches the ports of the watchdog for answer consistency and the input handshake over time.
// ----------------------------------------------------------------------------
module mswd_checker
    import mswd_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [1:0]              m_status,
    input logic [SLOT_FIELD_W-1:0] m_granted_slot,
    input logic                    m_expired,
    input logic [SLOT_FIELD_W-1:0] m_expired_slot
);

    // Hold a stalled answer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_granted_slot) && $stable(m_expired) && $stable(m_expired_slot))
        else $error("stalled answer changed");

    // Drop the answer channel after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("answer valid after reset");

    // A failed request carries no grant and no expiry
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> !m_expired && (m_granted_slot == '0))
        else $error("failed answer carries slot data");

    // An expiry is only reported with status ok
    a_exp_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_expired |-> (m_status == ST_OK) && (m_granted_slot == '0))
        else $error("expiry with wrong status");

    // Every request keeps the block busy in the cycle after it is accepted
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted on consecutive cycles");

endmodule

bind multi_slot_software_watchdog mswd_checker u_mswd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_granted_slot (m_granted_slot),
    .m_expired      (m_expired),
    .m_expired_slot (m_expired_slot)
);

// ===== test/tb_multi_slot_software_watchdog.sv =====
// ----------------------------------------------------------------------------
// Multi-slot watchdog testbench
// Drives allocate, release, kick and tick requests into the watchdog, keeps
// its own model of the slot table to predict every answer, and checks each
// answer field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_multi_slot_software_watchdog;
    import mswd_pkg::*;

    localparam int NUM_SLOTS   = 8;
    localparam int CNT_W       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = NUM_SLOTS + 6;
    localparam int PRINT_CAP   = 30;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // One answer as the watchdog should present it
    typedef struct packed {
        status_t                 status;
        logic [SLOT_FIELD_W-1:0] granted_slot;
        logic                    expired;
        logic [SLOT_FIELD_W-1:0] expired_slot;
    } answer_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    opcode_t                 s_opcode;
    logic [TMO_FIELD_W-1:0]  s_timeout_ticks;
    logic [SLOT_FIELD_W-1:0] s_slot_number;
    logic                    m_valid;
    logic                    m_ready;
    logic [1:0]              m_status;
    logic [SLOT_FIELD_W-1:0] m_granted_slot;
    logic                    m_expired;
    logic [SLOT_FIELD_W-1:0] m_expired_slot;

    // Shadow copy of the slot table
    logic             wd_busy  [NUM_SLOTS];
    logic [CNT_W-1:0] wd_limit [NUM_SLOTS];
    logic [CNT_W-1:0] wd_count [NUM_SLOTS];

    answer_t expected_answers[$];

    int cycle_count;
    int requests_sent;
    int answers_seen;
    int expiries_seen;
    int refusals_seen;
    int mismatch_count;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_cycles;

    multi_slot_software_watchdog #(
        .SLOT_COUNT  (NUM_SLOTS),
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_timeout_ticks (s_timeout_ticks),
        .s_slot_number   (s_slot_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_slot  (m_granted_slot),
        .m_expired       (m_expired),
        .m_expired_slot  (m_expired_slot)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog of the testbench itself: give up well past the slowest pass
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: apply one request to the shadow table, return its answer
    // ------------------------------------------------------------------
    task automatic predict_answer(input opcode_t op,
                                  input logic [TMO_FIELD_W-1:0] tmo,
                                  input logic [SLOT_FIELD_W-1:0] sn,
                                  output answer_t ans);
        logic             hit;
        logic [CNT_W-1:0] old;
        ans = '0;
        hit = 1'b0;
        ans.status = ST_OK;
        case (op)
            OP_ALLOC: begin
                // Take the lowest free slot, or refuse when the table is full
                ans.status = ST_FULL;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!hit && !wd_busy[i]) begin
                        hit = 1'b1;
                        wd_busy[i]  = 1'b1;
                        wd_limit[i] = (tmo > COUNT_MAX) ? COUNT_MAX : tmo[CNT_W-1:0];
                        wd_count[i] = '0;
                        ans.status = ST_OK;
                        ans.granted_slot = i[SLOT_FIELD_W-1:0];
                    end
                end
            end
            OP_RELEASE: begin
                if (sn >= NUM_SLOTS) begin
                    ans.status = ST_RANGE;
                end else if (!wd_busy[sn]) begin
                    ans.status = ST_FREE;
                end else begin
                    wd_busy[sn]  = 1'b0;
                    wd_limit[sn] = '0;
                    wd_count[sn] = '0;
                end
            end
            OP_KICK: begin
                // A kick of a free slot still zeroes its count and answers ok
                if (sn >= NUM_SLOTS)
                    ans.status = ST_RANGE;
                else
                    wd_count[sn] = '0;
            end
            default: begin
                // Advance in-use slots in order; stop at the first one whose
                // count before the advance is past its limit
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!hit && wd_busy[i]) begin
                        old = wd_count[i];
                        if (old != COUNT_MAX)
                            wd_count[i] = old + 1'b1;
                        if (old > wd_limit[i]) begin
                            hit = 1'b1;
                            ans.expired = 1'b1;
                            ans.expired_slot = i[SLOT_FIELD_W-1:0];
                        end
                    end
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender: offer one request, hold it until accepted, then predict
    // ------------------------------------------------------------------
    task automatic send_request(input opcode_t op,
                                input logic [TMO_FIELD_W-1:0] tmo,
                                input logic [SLOT_FIELD_W-1:0] sn);
        answer_t ans;
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_opcode        = op;
        s_timeout_ticks = tmo;
        s_slot_number   = sn;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_answer(op, tmo, sn, ans);
        expected_answers.push_back(ans);
        requests_sent++;
    endtask

    // Drop valid and hold off until every outstanding answer is in
    task automatic wait_for_answers();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_answers.size() != 0)
            @(posedge aclk);
    endtask

    // Pick an in-use slot most of the time, any slot otherwise
    function automatic logic [SLOT_FIELD_W-1:0] pick_slot();
        int busy_list[$];
        for (int i = 0; i < NUM_SLOTS; i++)
            if (wd_busy[i])
                busy_list.push_back(i);
        if (busy_list.size() != 0 && $urandom_range(9) < 8)
            return SLOT_FIELD_W'(busy_list[$urandom_range(busy_list.size() - 1)]);
        return SLOT_FIELD_W'($urandom_range(NUM_SLOTS - 1));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready = 1'b0;
                rx_hold_cycles--;
            end else begin
                m_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("MISMATCH cycle %0d answer %0d: %s got %0d want %0d",
                     cycle_count, answers_seen, what, got, want);
    endtask

    // Checker: compare each accepted answer with the oldest prediction
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
                report_mismatch("answer with none pending, status", m_status, 0);
            end else begin
                want = expected_answers.pop_front();
                if (want.expired)
                    expiries_seen++;
                if (want.status == ST_FULL)
                    refusals_seen++;
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_granted_slot !== want.granted_slot)
                    report_mismatch("granted_slot", m_granted_slot, want.granted_slot);
                if (m_expired !== want.expired)
                    report_mismatch("expired", m_expired, want.expired);
                if (m_expired_slot !== want.expired_slot)
                    report_mismatch("expired_slot", m_expired_slot, want.expired_slot);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table: tick finds nothing, release refuses, kick of a free slot is ok
    task automatic test_idle_table();
        send_request(OP_TICK, 16'h0000, 3'd0);
        send_request(OP_RELEASE, 16'hFFFF, 3'd3);
        send_request(OP_KICK, 16'h1234, 3'd5);
    endtask

    // Fill all slots with extreme limits, refuse one more, then free and reuse
    task automatic test_fill_and_refuse();
        logic [TMO_FIELD_W-1:0] limits [NUM_SLOTS];
        limits = '{16'h0000, 16'hFFFF, 16'h0001, 16'hAAAA,
                   16'h5555, 16'h0002, 16'h0003, 16'h8000};
        for (int i = 0; i < NUM_SLOTS; i++)
            send_request(OP_ALLOC, limits[i], SLOT_FIELD_W'($urandom_range(NUM_SLOTS - 1)));
        send_request(OP_ALLOC, 16'h0007, 3'd0);        // table full
        send_request(OP_RELEASE, 16'h0000, 3'd7);      // highest slot
        send_request(OP_RELEASE, 16'h0000, 3'd0);      // lowest slot
        send_request(OP_RELEASE, 16'h0000, 3'd0);      // already free
        send_request(OP_KICK, 16'h0000, 3'd7);         // kick a free slot
        send_request(OP_ALLOC, 16'h0000, 3'd2);        // lowest free is 0 again
    endtask

    // Expiry reports the first late slot only; kick and release move it on
    task automatic test_expiry_scan();
        send_request(OP_TICK, 16'h0000, 3'd0);
        send_request(OP_TICK, 16'h0000, 3'd0);
        send_request(OP_KICK, 16'h0000, 3'd0);
        send_request(OP_TICK, 16'h0000, 3'd0);
        send_request(OP_TICK, 16'h0000, 3'd0);
        send_request(OP_RELEASE, 16'h0000, 3'd0);
        send_request(OP_TICK, 16'h0000, 3'd0);
    endtask

    // Mixed traffic, biased so that slots fill, expire and get serviced
    task automatic test_random_traffic(input int n_requests);
        int                     pick;
        opcode_t                op;
        logic [TMO_FIELD_W-1:0] tmo;
        logic [SLOT_FIELD_W-1:0] sn;
        for (int i = 0; i < n_requests; i++) begin
            // Run a long stretch with both sides busy every cycle
            if (i == n_requests / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (i == n_requests / 2) begin
                tx_idle_pct = 34;
                rx_idle_pct = 34;
            end
            pick = $urandom_range(99);
            tmo  = TMO_FIELD_W'(($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                                         : $urandom_range(12));
            sn   = SLOT_FIELD_W'($urandom_range(NUM_SLOTS - 1));
            if (pick < 22) begin
                op = OP_ALLOC;
            end else if (pick < 38) begin
                op = OP_RELEASE;
                sn = pick_slot();
            end else if (pick < 56) begin
                op = OP_KICK;
                sn = pick_slot();
            end else begin
                op = OP_TICK;
            end
            send_request(op, tmo, sn);
        end
    endtask

    // Hold the answer side off so the block fills and stalls its input
    task automatic test_backpressure();
        rx_hold_cycles = 300;
        tx_idle_pct = 0;
        for (int i = 0; i < 10; i++)
            send_request((i % 4 == 0) ? OP_ALLOC : OP_TICK,
                         TMO_FIELD_W'($urandom_range(4)),
                         SLOT_FIELD_W'($urandom_range(NUM_SLOTS - 1)));
        tx_idle_pct = 34;
        wait_for_answers();
    endtask

    // Slots limited at and just below the count maximum stay quiet over a
    // run of ticks
    task automatic test_large_limits();
        for (int i = 0; i < NUM_SLOTS; i++)
            if (wd_busy[i])
                send_request(OP_RELEASE, TMO_FIELD_W'($urandom_range(16'hFFFF)),
                             i[SLOT_FIELD_W-1:0]);
        send_request(OP_ALLOC, COUNT_MAX, 3'd0);
        send_request(OP_ALLOC, COUNT_MAX - 1'b1, 3'd0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < 40; i++)
            send_request(OP_TICK, 16'h0000, 3'd0);
        tx_idle_pct = 34;
        rx_idle_pct = 34;
        wait_for_answers();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        s_valid         = 1'b0;
        s_opcode        = OP_TICK;
        s_timeout_ticks = '0;
        s_slot_number   = '0;
        aresetn         = 1'b0;
        requests_sent   = 0;
        answers_seen    = 0;
        expiries_seen   = 0;
        refusals_seen   = 0;
        mismatch_count  = 0;
        rx_hold_cycles  = 0;
        tx_idle_pct     = 34;
        rx_idle_pct     = 34;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            wd_busy[i]  = 1'b0;
            wd_limit[i] = '0;
            wd_count[i] = '0;
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_idle_table();
        test_fill_and_refuse();
        test_expiry_scan();
        wait_for_answers();
        test_random_traffic(1020);
        wait_for_answers();
        test_backpressure();
        test_large_limits();

        // Let any late or spurious answer show up before judging
        wait_for_answers();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d requests, checked %0d answers in %0d cycles",
                 requests_sent, answers_seen, cycle_count);
        $display("Saw %0d expiries and %0d full-table refusals, %0d mismatches",
                 expiries_seen, refusals_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mswd_pkg.sv
hdl/multi_slot_software_watchdog.sv
hdl/mswd_checker.sv
test/tb_multi_slot_software_watchdog.sv
